// ===== rtl/core/ring_deque_with_search_sort_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Ring deque assertion macros
// Concurrent check helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RING_DEQUE_WITH_SEARCH_SORT_UNIT_DEFINES_SVH
`define RING_DEQUE_WITH_SEARCH_SORT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Hold prop at every edge outside reset.
`define RDQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rdq: check failed");
// Require post in the cycle after pre.
`define RDQ_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rdq: sequence check failed");
`else
`define RDQ_ASSERT(label, prop)
`define RDQ_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== rtl/core/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring deque package
// Command and status codes, item structs and sequencer states.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK       = 3'd4,
		CMD_LENGTH     = 3'd5,
		CMD_SEARCH     = 3'd6,
		CMD_SORT       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SRCH,
		S_SLOAD,
		S_SSTEP,
		S_SEND,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		status_t                  status;
		logic                     found;
		logic [3:0]               position;
		logic [4:0]               count;
	} out_t;

endpackage

// ===== rtl/core/rdq_ram.sv =====
// ----------------------------------------------------------------------------
// Ring deque entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdq_ram
	import rdq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic [AW-1:0]            rd_addr,
	output logic signed [DATA_W-1:0] rd_data
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/ring_deque_with_search_sort_unit.sv =====
// ----------------------------------------------------------------------------
// Ring deque with search and sort: push, length and full/empty cases go from idle
// straight to done, pop and peek read one entry, search scans and sort runs bubble passes.
// One item at a time; every read goes through the entry memory's one registered
// read port. A stalled response holds the block in its last step until it drains.
// Reset clears pointers, count and handshakes; entry contents stay undefined.
// ----------------------------------------------------------------------------
`include "ring_deque_with_search_sort_unit_defines.svh"

module ring_deque_with_search_sort_unit
	import rdq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  in_t  cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output out_t rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW:0] CAP_EXT = (CW + 1)'(CAPACITY);

	state_t                   state_q, state_d;
	logic [IW-1:0]            front_q, front_d;
	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            idx_q, idx_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	logic signed [DATA_W-1:0] carry_q, carry_d;
	logic                     swap_q, swap_d;
	out_t                     res_q, res_d;
	out_t                     rsp_q, rsp_d;
	logic                     rsp_valid_q, rsp_valid_d;

	logic                     wr_en;
	logic [IW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [IW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic                     acc;
	logic                     gt;
	logic [CW-1:0]            idx_inc;

	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
		input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, pos};
		if (sum >= CAP_EXT) begin
			sum = sum - CAP_EXT;
		end
		return sum[IW-1:0];
	endfunction

	rdq_ram #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign acc     = cmd_valid && (state_q == S_IDLE);
	assign gt      = carry_q > rd_data;
	assign idx_inc = idx_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			swap_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			swap_q      <= swap_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q   <= val_d;
		carry_q <= carry_d;
		res_q   <= res_d;
		rsp_q   <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		count_d     = count_q;
		idx_d       = idx_q;
		val_d       = val_q;
		carry_d     = carry_q;
		swap_d      = swap_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		wr_en       = 1'b0;
		wr_addr     = front_q;
		wr_data     = val_q;
		rd_addr     = front_q;

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					val_d        = cmd.value;
					res_d        = '0;
					res_d.status = ST_OK;
					state_d      = S_DONE;
					case (cmd.command)
						CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
							if (count_q == CW'(CAPACITY)) begin
								res_d.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_data = cmd.value;
								count_d = count_q + CW'(1);
								if (cmd.command == CMD_PUSH_FRONT) begin
									front_d = (front_q == '0) ? IW'(CAPACITY - 1)
										: front_q - IW'(1);
									wr_addr = front_d;
								end else begin
									wr_addr = slot_of(front_q, count_q);
								end
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK: begin
							if (count_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								state_d = S_POP;
								if (cmd.command == CMD_POP_FRONT) begin
									front_d = (front_q == IW'(CAPACITY - 1)) ? '0
										: front_q + IW'(1);
									count_d = count_q - CW'(1);
								end else if (cmd.command == CMD_POP_BACK) begin
									rd_addr = slot_of(front_q, count_q - CW'(1));
									count_d = count_q - CW'(1);
								end
							end
						end
						CMD_SEARCH: begin
							if (count_q != '0) begin
								idx_d   = CW'(1);
								state_d = S_SRCH;
							end
						end
						CMD_SORT: begin
							if (count_q >= CW'(2)) begin
								idx_d   = CW'(1);
								swap_d  = 1'b0;
								state_d = S_SLOAD;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_POP: begin
				res_d.data_out = rd_data;
				state_d        = S_DONE;
			end
			S_SRCH: begin
				// rd_data holds the entry at position idx_q - 1
				if (rd_data == val_q) begin
					res_d.found    = 1'b1;
					res_d.position = 4'(idx_q - CW'(1));
					state_d        = S_DONE;
				end else if (idx_q == count_q) begin
					state_d = S_DONE;
				end else begin
					rd_addr = slot_of(front_q, idx_q);
					idx_d   = idx_inc;
				end
			end
			S_SLOAD: begin
				carry_d = rd_data;
				rd_addr = slot_of(front_q, idx_q);
				state_d = S_SSTEP;
			end
			S_SSTEP: begin
				// drop the smaller one behind, carry the larger one forward
				wr_en   = 1'b1;
				wr_addr = slot_of(front_q, idx_q - CW'(1));
				wr_data = gt ? rd_data : carry_q;
				carry_d = gt ? carry_q : rd_data;
				if (gt) begin
					swap_d = 1'b1;
				end
				if (idx_inc == count_q) begin
					state_d = S_SEND;
				end else begin
					rd_addr = slot_of(front_q, idx_inc);
					idx_d   = idx_inc;
				end
			end
			S_SEND: begin
				wr_en   = 1'b1;
				wr_addr = slot_of(front_q, idx_q);
				wr_data = carry_q;
				if (swap_q) begin
					idx_d   = CW'(1);
					swap_d  = 1'b0;
					state_d = S_SLOAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d       = res_q;
					rsp_d.count = 5'(count_q);
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RDQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY))
	`RDQ_ASSERT(a_front_bound, front_q <= IW'(CAPACITY - 1))
	`RDQ_ASSERT(a_sort_index, (state_q == S_SSTEP) |-> (idx_q < count_q && idx_q != '0))
	`RDQ_ASSERT_NEXT(a_pop_count, acc && cmd.command == CMD_POP_FRONT && count_q != '0,
		count_q == $past(count_q) - CW'(1))

endmodule
